// ===== rtl/core/cwnc_pkg.sv =====
// shared types, widths and constants of the cosine weighted neighbor count
package cwnc_pkg;

  localparam int COORD_W          = 20;
  localparam int THR_W            = COORD_W - 1;
  localparam int DIFF_W           = COORD_W + 1;
  localparam int SQ_W             = 2 * DIFF_W;
  localparam int ROOT_W           = DIFF_W;
  localparam int REM_W            = ROOT_W + 3;
  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int WEIGHT_W         = WEIGHT_FRAC_BITS + 1;
  localparam int OUT_SUM_W        = 29;
  localparam int SUM_W            = 34;
  localparam int MAX_POINTS_DEF   = 4096;
  localparam int MUL_A_W          = 33;
  localparam int MUL_B_W          = 32;
  localparam int MUL_P_W          = MUL_A_W + MUL_B_W;
  localparam int CFG_ADDR_W       = 3;

  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_CENTER_X  = 3'd0,
    REG_CENTER_Y  = 3'd1,
    REG_CENTER_Z  = 3'd2,
    REG_LOW_THR   = 3'd3,
    REG_HIGH_THR  = 3'd4
  } cfg_reg_t;

  // horner denominators of the cosine series and floor(2^32 / k)
  localparam logic [7:0] HDEN [8] = '{8'd240, 8'd182, 8'd132, 8'd90,
                                      8'd56, 8'd30, 8'd12, 8'd2};
  localparam logic [31:0] HRECIP [8] = '{32'd17895697, 32'd23598721, 32'd32537631,
                                         32'd47721858, 32'd76695844, 32'd143165576,
                                         32'd357913941, 32'd2147483648};

endpackage

// ===== rtl/core/cwnc_if.sv =====
// point and result channel interfaces
interface cwnc_in_if;
  import cwnc_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] point_x;
  logic [COORD_W-1:0] point_y;
  logic [COORD_W-1:0] point_z;
  logic               defined;
  logic               last_point;
  modport source (output valid, point_x, point_y, point_z, defined, last_point,
                  input ready);
  modport sink (input valid, point_x, point_y, point_z, defined, last_point,
                output ready);
endinterface

interface cwnc_out_if;
  import cwnc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OUT_SUM_W-1:0] weight_total;
  logic                 saturated;
  modport source (output valid, weight_total, saturated, input ready);
  modport sink (input valid, weight_total, saturated, output ready);
endinterface

// ===== rtl/core/cosine_weighted_neighbor_count.sv =====
// top level of the cosine weighted neighbor count
// Takes one 3D point per beat and adds a cosine-shaped weight of its distance from the
// configured center to a running sum; a beat marked last returns the sum (Q16, clipped at
// MAX_POINTS) and clears it. A defined point inside the cosine band passes the accept
// step, the squares, the bit-pair square root, the threshold compare, the restoring phase
// divide, the angle, the cosine series (8 horner steps) and the rounding, and is then
// accumulated; the squares, the angle and the series share one 33x32 multiplier. A point
// outside the band skips the divide and the series, and an undefined point adds nothing.
// A last point then hands its sum to the output register, waiting while that register
// still holds an untaken result. The block takes no point while one is in flight. A finished
// result sits in the output register, so the next point is taken while it waits, unless a
// second sum is ready before the first one was taken.
module cosine_weighted_neighbor_count #(
  parameter int MAX_POINTS = cwnc_pkg::MAX_POINTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  cwnc_in_if.sink                          in_ch,
  cwnc_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [cwnc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [cwnc_pkg::COORD_W-1:0]     cfg_wdata
);
  import cwnc_pkg::*;

  localparam logic [SUM_W-1:0] SUM_LIMIT = SUM_W'(MAX_POINTS) << WEIGHT_FRAC_BITS;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_SQ   = 14'b00000000000010,
    S_SQRT = 14'b00000000000100,
    S_CMP  = 14'b00000000001000,
    S_DIV  = 14'b00000000010000,
    S_ANG  = 14'b00000000100000,
    S_Y    = 14'b00000001000000,
    S_LY2  = 14'b00000010000000,
    S_HM   = 14'b00000100000000,
    S_HR   = 14'b00001000000000,
    S_HC   = 14'b00010000000000,
    S_RND  = 14'b00100000000000,
    S_ACC  = 14'b01000000000000,
    S_OUT  = 14'b10000000000000
  } state_t;

  // configuration
  logic [COORD_W-1:0] cx_r, cy_r, cz_r;
  logic [THR_W-1:0]   lo_r, hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0; cy_r <= '0; cz_r <= '0; lo_r <= '0; hi_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CENTER_X: cx_r <= cfg_wdata;
        REG_CENTER_Y: cy_r <= cfg_wdata;
        REG_CENTER_Z: cz_r <= cfg_wdata;
        REG_LOW_THR:  lo_r <= cfg_wdata[THR_W-1:0];
        REG_HIGH_THR: hi_r <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic [DIFF_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b);
    logic [DIFF_W-1:0] d;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    return d[DIFF_W-1] ? (~d + 1'b1) : d;
  endfunction

  state_t              state_r;
  logic [4:0]          cnt_r;
  logic [2:0]          k_r;
  logic                last_r;
  logic [DIFF_W-1:0]   ax_r, ay_r, az_r;
  logic [SQ_W-1:0]     sq_r;
  logic [ROOT_W-1:0]   root_r;
  logic [REM_W-1:0]    rem_r;
  logic [THR_W-1:0]    span_r, drem_r;
  logic [31:0]         t_r;
  logic [31:0]         y2_r;
  logic [30:0]         p_r;
  logic [32:0]         m_r;
  logic [WEIGHT_W-1:0] w_r;
  logic [SUM_W-1:0]    sum_r;
  logic                ovf_r;
  logic                out_valid_r;
  logic [OUT_SUM_W-1:0] out_cnt_r;
  logic                out_sat_r;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  cwnc_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  // phase fold: past a quarter period the cosine is mirrored
  logic        neg;
  logic [31:0] u_fold;
  assign neg    = t_r[31] && (|t_r[30:0]);
  assign u_fold = neg ? (~t_r + 32'd1) : t_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_SQ: begin
        unique case (cnt_r[1:0])
          2'd0: begin mul_a = MUL_A_W'(ax_r); mul_b = MUL_B_W'(ax_r); end
          2'd1: begin mul_a = MUL_A_W'(ay_r); mul_b = MUL_B_W'(ay_r); end
          default: begin mul_a = MUL_A_W'(az_r); mul_b = MUL_B_W'(az_r); end
        endcase
      end
      S_ANG: begin mul_a = MUL_A_W'(u_fold); mul_b = PI_Q30; end
      S_Y:   begin mul_a = MUL_A_W'(mul_p[63:32]); mul_b = mul_p[63:32]; end
      S_HM:  begin mul_a = MUL_A_W'(y2_r); mul_b = MUL_B_W'(p_r); end
      S_HR:  begin mul_a = mul_p[62:30]; mul_b = HRECIP[k_r]; end
      default: ;
    endcase
  end

  // square root step: two radicand bits per cycle
  logic [REM_W-1:0] sr_sh, sr_trial;
  assign sr_sh    = {rem_r[REM_W-3:0], sq_r[SQ_W-1:SQ_W-2]};
  assign sr_trial = {1'b0, root_r, 2'b01};

  // divide step: one quotient bit per cycle
  logic [THR_W:0] dv_sh;
  assign dv_sh = {drem_r, 1'b0};

  // horner correction: reciprocal estimate is at most two low
  logic [32:0] q0;
  logic [40:0] q0k, cr;
  logic [33:0] qc;
  logic [8:0]  kk;
  assign q0  = mul_p[64:32];
  assign q0k = 41'(q0) * 41'(HDEN[k_r]);
  assign cr  = 41'(m_r) - q0k;
  assign kk  = {HDEN[k_r], 1'b0};
  always_comb begin
    priority if (cr >= 41'(kk))        qc = 34'(q0) + 34'd2;
    else if (cr >= 41'(HDEN[k_r]))     qc = 34'(q0) + 34'd1;
    else                               qc = 34'(q0);
  end

  // rounding of twice the weight in Q2.30 down to the output weight
  logic [31:0] w31;
  assign w31 = neg ? (32'(Q30_ONE) - 32'(p_r)) : (32'(Q30_ONE) + 32'(p_r));

  logic [SUM_W-1:0] sum_add;
  assign sum_add = sum_r + SUM_W'(w_r);

  assign in_ch.ready = (state_r == S_IDLE);
  logic in_acc;
  assign in_acc = in_ch.valid && in_ch.ready;

  // output register is loaded from S_OUT once it is free or being taken
  logic out_load;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      k_r         <= '0;
      last_r      <= 1'b0;
      sum_r       <= '0;
      ovf_r       <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            last_r <= in_ch.last_point;
            if (in_ch.defined) begin
              ax_r    <= abs_diff(in_ch.point_x, cx_r);
              ay_r    <= abs_diff(in_ch.point_y, cy_r);
              az_r    <= abs_diff(in_ch.point_z, cz_r);
              sq_r    <= '0;
              cnt_r   <= '0;
              state_r <= S_SQ;
            end else if (in_ch.last_point) begin
              state_r <= S_OUT;
            end
          end
        end
        S_SQ: begin
          if (cnt_r != 5'd0) sq_r <= sq_r + SQ_W'(mul_p);
          if (cnt_r == 5'd3) begin
            rem_r   <= '0;
            root_r  <= '0;
            cnt_r   <= 5'(ROOT_W - 1);
            state_r <= S_SQRT;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_SQRT: begin
          sq_r <= sq_r << 2;
          if (sr_sh >= sr_trial) begin
            rem_r  <= sr_sh - sr_trial;
            root_r <= {root_r[ROOT_W-2:0], 1'b1};
          end else begin
            rem_r  <= sr_sh;
            root_r <= {root_r[ROOT_W-2:0], 1'b0};
          end
          if (cnt_r == 5'd0) state_r <= S_CMP;
          else cnt_r <= cnt_r - 5'd1;
        end
        S_CMP: begin
          if (root_r <= ROOT_W'(lo_r)) begin
            w_r     <= WEIGHT_W'(1) << WEIGHT_FRAC_BITS;
            state_r <= S_ACC;
          end else if (root_r >= ROOT_W'(hi_r)) begin
            w_r     <= '0;
            state_r <= S_ACC;
          end else begin
            drem_r  <= root_r[THR_W-1:0] - lo_r;
            span_r  <= hi_r - lo_r;
            t_r     <= '0;
            cnt_r   <= 5'd31;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (dv_sh >= {1'b0, span_r}) begin
            drem_r <= THR_W'(dv_sh - {1'b0, span_r});
            t_r    <= {t_r[30:0], 1'b1};
          end else begin
            drem_r <= dv_sh[THR_W-1:0];
            t_r    <= {t_r[30:0], 1'b0};
          end
          if (cnt_r == 5'd0) state_r <= S_ANG;
          else cnt_r <= cnt_r - 5'd1;
        end
        S_ANG: state_r <= S_Y;
        S_Y:   state_r <= S_LY2;
        S_LY2: begin
          y2_r    <= mul_p[61:30];
          p_r     <= Q30_ONE;
          k_r     <= '0;
          state_r <= S_HM;
        end
        S_HM: state_r <= S_HR;
        S_HR: begin
          m_r     <= mul_p[62:30];
          state_r <= S_HC;
        end
        S_HC: begin
          p_r <= (qc >= 34'(Q30_ONE)) ? '0 : 31'(34'(Q30_ONE) - qc);
          if (k_r == 3'd7) state_r <= S_RND;
          else begin
            k_r     <= k_r + 3'd1;
            state_r <= S_HM;
          end
        end
        S_RND: begin
          w_r     <= WEIGHT_W'((w31 + 32'(1 << 14)) >> 15);
          state_r <= S_ACC;
        end
        // saturating accumulate of the settled weight
        S_ACC: begin
          if (sum_add > SUM_LIMIT) begin
            sum_r <= SUM_LIMIT;
            ovf_r <= 1'b1;
          end else begin
            sum_r <= sum_add;
          end
          state_r <= last_r ? S_OUT : S_IDLE;
        end
        S_OUT: begin
          if (out_load) begin
            out_cnt_r   <= sum_r[OUT_SUM_W-1:0];
            out_sat_r   <= ovf_r;
            sum_r       <= '0;
            ovf_r       <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.weight_total   = out_cnt_r;
  assign out_ch.saturated      = out_sat_r;
endmodule

// ===== rtl/core/cwnc_mul.sv =====
// shared unsigned multiplier with registered product
module cwnc_mul (
  input  logic                          clk,
  input  logic [cwnc_pkg::MUL_A_W-1:0]  a,
  input  logic [cwnc_pkg::MUL_B_W-1:0]  b,
  output logic [cwnc_pkg::MUL_P_W-1:0]  p
);
  import cwnc_pkg::*;

  logic [MUL_P_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= MUL_P_W'(a) * MUL_P_W'(b);
  end

  assign p = p_r;
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// queue-driven testbench with a scoreboard for the cosine weighted neighbor count
module testbench;
  import cwnc_pkg::*;

  // one point beat as the driver puts it on the wire
  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               defined;
    logic               last_point;
  } point_beat_t;

  // one result beat as the scoreboard expects it
  typedef struct {
    logic [OUT_SUM_W-1:0] count;
    logic                 saturated;
  } count_beat_t;

  localparam longint unsigned PI_Q2_30  = 64'd3373259426;
  localparam longint unsigned ONE_Q2_30 = 64'd1 << 30;
  localparam longint unsigned SUM_CAP   = 64'd4096 << WEIGHT_FRAC_BITS;
  localparam int              SETTLE    = 150;  // a bit over the slowest in-band point
  localparam logic [COORD_W-1:0] C_MIN  = 20'h80000;
  localparam logic [COORD_W-1:0] C_MAX  = 20'h7ffff;
  localparam logic [THR_W-1:0]   T_MAX  = 19'h7ffff;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [COORD_W-1:0] cfg_wdata = '0;

  cwnc_in_if  in_ch ();
  cwnc_out_if out_ch ();

  cosine_weighted_neighbor_count dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // the scoreboard's own copy of the register file and the running sum
  logic signed [COORD_W-1:0] ctr_x, ctr_y, ctr_z;
  logic [THR_W-1:0]          thr_low, thr_high;
  longint unsigned           run_sum;
  logic                      run_clipped;

  point_beat_t pending_points[$];
  count_beat_t sums_due[$];
  int          mismatches = 0;
  int          send_idle_pct = 28;
  int          recv_idle_pct = 54;
  logic        in_beat_taken = 1'b0;

  localparam longint unsigned SERIES_DEN [8] = '{240, 182, 132, 90, 56, 30, 12, 2};

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // cos(pi * u / 2^32) in Q2.30, u folded into the first quarter turn
  function automatic longint unsigned half_turn_cos(longint unsigned u);
    longint unsigned ang, ang_sq, acc, q;
    ang = (u * PI_Q2_30) >> 32;
    ang_sq = (ang * ang) >> 30;
    acc = ONE_Q2_30;
    for (int k = 0; k < 8; k++) begin
      q = (ang_sq * acc) / (SERIES_DEN[k] << 30);
      acc = (q >= ONE_Q2_30) ? 0 : ONE_Q2_30 - q;
    end
    return acc;
  endfunction

  function automatic longint unsigned axis_gap(logic [COORD_W-1:0] p,
                                               logic signed [COORD_W-1:0] c);
    longint signed g;
    g = longint'($signed(p)) - longint'(c);
    return (g < 0) ? -g : g;
  endfunction

  // neighbor weight in Q16 of a point at the given distance
  function automatic longint unsigned cosine_weight(longint unsigned radius);
    longint unsigned phase, twice_w, lo, hi;
    lo = thr_low;
    hi = thr_high;
    if (radius <= lo) return 64'd1 << WEIGHT_FRAC_BITS;
    if (radius >= hi) return 0;
    phase = ((radius - lo) << 32) / (hi - lo);
    if (phase <= (64'd1 << 31)) twice_w = ONE_Q2_30 + half_turn_cos(phase);
    else twice_w = ONE_Q2_30 - half_turn_cos((64'd1 << 32) - phase);
    // round half up from Q31 to Q16
    return (twice_w + (64'd1 << (30 - WEIGHT_FRAC_BITS))) >> (31 - WEIGHT_FRAC_BITS);
  endfunction

  // fold one accepted point into the running sum, queue a result on the last one
  function automatic void accumulate_point(point_beat_t p);
    longint unsigned gx, gy, gz, w;
    count_beat_t r;
    if (p.defined) begin
      gx = axis_gap(p.x, ctr_x);
      gy = axis_gap(p.y, ctr_y);
      gz = axis_gap(p.z, ctr_z);
      w = cosine_weight(floor_sqrt(gx * gx + gy * gy + gz * gz));
      if (run_sum > SUM_CAP - w) begin
        run_sum = SUM_CAP;
        run_clipped = 1'b1;
      end else begin
        run_sum += w;
      end
    end
    if (p.last_point) begin
      r.count = run_sum[OUT_SUM_W-1:0];
      r.saturated = run_clipped;
      sums_due.push_back(r);
      run_sum = 0;
      run_clipped = 1'b0;
    end
  endfunction

  task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
    $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
    mismatches++;
  endtask

  // driver: a new beat goes out once the previous one was taken
  always @(negedge clk) begin
    point_beat_t p;
    if (rst_n && (!in_ch.valid || in_beat_taken)) begin
      if (pending_points.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        p = pending_points.pop_front();
        in_ch.point_x    <= p.x;
        in_ch.point_y    <= p.y;
        in_ch.point_z    <= p.z;
        in_ch.defined    <= p.defined;
        in_ch.last_point <= p.last_point;
        in_ch.valid      <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor: predict on accepted points, check on accepted results
  always @(posedge clk) begin
    point_beat_t p;
    count_beat_t want;
    in_beat_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      p.x = in_ch.point_x;
      p.y = in_ch.point_y;
      p.z = in_ch.point_z;
      p.defined = in_ch.defined;
      p.last_point = in_ch.last_point;
      accumulate_point(p);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (sums_due.size() == 0) begin
        report_mismatch("unexpected result, count", 0, out_ch.weight_total);
      end else begin
        want = sums_due.pop_front();
        if (out_ch.weight_total !== want.count)
          report_mismatch("weight_total", want.count, out_ch.weight_total);
        if (out_ch.saturated !== want.saturated)
          report_mismatch("saturated", want.saturated, out_ch.saturated);
      end
    end
  end

  // register writes happen only with the block idle
  task automatic write_reg(cfg_reg_t idx, logic [COORD_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_CENTER_X: ctr_x = val;
      REG_CENTER_Y: ctr_y = val;
      REG_CENTER_Z: ctr_z = val;
      REG_LOW_THR:  thr_low = val[THR_W-1:0];
      REG_HIGH_THR: thr_high = val[THR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_geometry(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                              logic [COORD_W-1:0] cz, logic [THR_W-1:0] lo,
                              logic [THR_W-1:0] hi);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_LOW_THR, {1'b0, lo});
    write_reg(REG_HIGH_THR, {1'b0, hi});
  endtask

  // wait until every point went in and every sum came out, then let the last
  // result-less point drain out of the datapath
  task automatic drain;
    while (pending_points.size() != 0 || in_ch.valid || sums_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic push_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic [COORD_W-1:0] z, logic def, logic lst);
    point_beat_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    p.defined = def;
    p.last_point = lst;
    pending_points.push_back(p);
  endtask

  // mostly near the center within the given reach, sometimes anywhere or at an extreme
  function automatic logic [COORD_W-1:0] near_coord(logic signed [COORD_W-1:0] c, int reach);
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return COORD_W'($urandom);
    if (pick == 1) return ($urandom_range(1) != 0) ? C_MIN : C_MAX;
    return COORD_W'(int'(c) + (int'($urandom_range(2 * reach)) - reach));
  endfunction

  // random sets of a few points each
  task automatic random_points(int count, int reach);
    int left;
    left = 0;
    for (int i = 0; i < count; i++) begin
      if (left == 0) left = int'($urandom_range(10, 1));
      left--;
      push_point(near_coord(ctr_x, reach), near_coord(ctr_y, reach),
                 near_coord(ctr_z, reach), $urandom_range(9) != 0,
                 left == 0 || i == count - 1);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.point_z = '0;
    in_ch.defined = 1'b0;
    in_ch.last_point = 1'b0;
    out_ch.ready = 1'b0;
    ctr_x = '0;
    ctr_y = '0;
    ctr_z = '0;
    thr_low = '0;
    thr_high = '0;
    run_sum = 0;
    run_clipped = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset geometry: only the center itself weighs one
    push_point('0, '0, '0, 1'b1, 1'b0);
    push_point(C_MIN, C_MIN, C_MIN, 1'b1, 1'b0);
    push_point(C_MAX, C_MAX, C_MAX, 1'b1, 1'b1);
    push_point(20'h12345, 20'habcde, 20'h55aa5, 1'b0, 1'b1);   // skipped point still emits
    push_point('0, '0, '0, 1'b1, 1'b1);
    push_point('0, '0, '0, 1'b0, 1'b0);
    push_point('0, '0, '0, 1'b1, 1'b1);
    drain();

    // band of 2560..12800: on each edge, mid band and both halves of the turn
    set_geometry('0, '0, '0, 19'd2560, 19'd12800);
    push_point(20'd2560, '0, '0, 1'b1, 1'b0);
    push_point(20'd2561, '0, '0, 1'b1, 1'b0);
    push_point(20'd7680, '0, '0, 1'b1, 1'b0);
    push_point('0, 20'd5000, '0, 1'b1, 1'b0);
    push_point('0, '0, -20'sd10000, 1'b1, 1'b0);
    push_point(20'd12799, '0, '0, 1'b1, 1'b0);
    push_point(20'd12800, '0, '0, 1'b1, 1'b1);
    random_points(400, 9000);
    drain();

    // crossed thresholds with the centers at the extremes, then a full band around a random center
    send_idle_pct = 54;
    recv_idle_pct = 28;
    set_geometry(C_MIN, C_MAX, '0, T_MAX, '0);
    random_points(200, 600000);
    drain();
    set_geometry(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom), '0, T_MAX);
    random_points(200, 300000);
    drain();

    // wide band with no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_geometry('0, '0, '0, 19'd1000, T_MAX);
    random_points(300, 400000);
    drain();

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // hang guard
  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
